// ===== rtl/core/gbe_pkg.sv =====
// Package for the Golomb bitstream encoder.
// Holds the fixed widths, the command type passed from front to back and the
// front controller state type. It depends on nothing else.
package gbe_pkg;

  localparam int DIV_W  = 11;   // width of the divisor register
  localparam int MAX_B  = 11;   // largest remainder code width
  localparam int B_W    = 4;    // holds 0..MAX_B
  localparam int TAIL_W = 12;   // stop bit plus the longest remainder code
  localparam int TLEN_W = 4;    // holds 0..TAIL_W

  localparam logic [DIV_W-1:0] DIVISOR_RESET = DIV_W'(1);

  // Everything after the unary run: its length and its bits, right-aligned.
  typedef struct packed {
    logic              flush;
    logic [TLEN_W-1:0] len;
    logic [TAIL_W-1:0] bits;
  } tail_t;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  // Smallest b with 2^b >= m.
  function automatic logic [B_W-1:0] code_width(input logic [DIV_W-1:0] m);
    logic [B_W-1:0] b;
    b = '0;
    for (int k = 0; k <= MAX_B; k++) begin
      if (((DIV_W+1)'(1) << k) < {1'b0, m}) begin
        b = B_W'(k + 1);
      end
    end
    return b;
  endfunction

endpackage

// ===== rtl/core/gbe_fifo.sv =====
// Small first-in first-out queue built from flip-flops.
// Used between the front and back ends and in front of the result ports.
// No package dependency.
module gbe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== rtl/core/gbe_front.sv =====
// Front end of the Golomb encoder: accepts requests, divides the value by the
// divisor one bit per cycle and forms the unary length and remainder code.
// Depends on gbe_pkg.
module gbe_front import gbe_pkg::*; #(
  parameter int VALUE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_func,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  in_full,
  input  logic [DIV_W-1:0]      divisor,
  output logic                  cmd_push,
  input  logic                  cmd_full,
  output logic [VALUE_BITS-1:0] cmd_ones,
  output tail_t                 cmd_tail
);

  localparam int STEP_W = $clog2(VALUE_BITS + 1);

  front_state_t          state_r, state_nxt;
  logic                  flush_r;
  logic [VALUE_BITS-1:0] dvd_r;
  logic [VALUE_BITS-1:0] quo_r;
  logic [DIV_W-1:0]      rem_r;
  logic [STEP_W-1:0]     step_r;

  logic [DIV_W-1:0]  m_eff;
  logic [DIV_W:0]    rem_sh;
  logic              ge;
  logic [DIV_W:0]    rem_new;
  logic [B_W-1:0]    b;
  logic [TAIL_W-1:0] u;
  logic [TAIL_W-1:0] r_ext;

  assign m_eff   = (divisor == '0) ? DIV_W'(1) : divisor;
  assign rem_sh  = {rem_r, dvd_r[VALUE_BITS-1]};
  assign ge      = (rem_sh >= {1'b0, m_eff});
  assign rem_new = ge ? (rem_sh - {1'b0, m_eff}) : rem_sh;

  // Truncated binary: remainders below u take b-1 bits, the rest are offset
  // by u and take b bits. The stop bit of the unary run is the leading zero.
  assign b     = code_width(m_eff);
  assign u     = (TAIL_W'(1) << b) - TAIL_W'(m_eff);
  assign r_ext = TAIL_W'(rem_r);

  always_comb begin
    cmd_tail.flush = flush_r;
    cmd_ones       = flush_r ? '0 : quo_r;
    if (flush_r) begin
      cmd_tail.len  = '0;
      cmd_tail.bits = '0;
    end else if (r_ext < u) begin
      cmd_tail.len  = TLEN_W'(b);
      cmd_tail.bits = r_ext;
    end else begin
      cmd_tail.len  = TLEN_W'(b) + TLEN_W'(1);
      cmd_tail.bits = r_ext + u;
    end
  end

  assign in_full  = (state_r != F_IDLE);
  assign cmd_push = (state_r == F_PUSH);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_push) begin
          state_nxt = in_func ? F_PUSH : F_DIV;
        end
      end
      F_DIV: begin
        if (step_r == STEP_W'(VALUE_BITS - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!cmd_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_push) begin
      flush_r <= in_func;
      dvd_r   <= in_value;
      quo_r   <= '0;
      rem_r   <= '0;
      step_r  <= '0;
    end else if (state_r == F_DIV) begin
      dvd_r  <= {dvd_r[VALUE_BITS-2:0], 1'b0};
      quo_r  <= {quo_r[VALUE_BITS-2:0], ge};
      rem_r  <= rem_new[DIV_W-1:0];
      step_r <= step_r + STEP_W'(1);
    end
  end

endmodule

// ===== rtl/core/gbe_back.sv =====
// Back end of the Golomb encoder: appends the unary run, then the remainder
// code, to the pending word, as many bits of the current part a cycle as the
// word has room for while the result queue is not full. Depends on gbe_pkg.
module gbe_back import gbe_pkg::*; #(
  parameter int VALUE_BITS = 10,
  parameter int WORD_BITS  = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cmd_empty,
  output logic                             cmd_pop,
  input  logic [VALUE_BITS-1:0]            cmd_ones,
  input  tail_t                            cmd_tail,
  input  logic                             out_full,
  output logic                             out_push,
  output logic [WORD_BITS-1:0]             out_word,
  output logic [$clog2(WORD_BITS+1)-1:0]   out_bit_count,
  output logic                             out_last
);

  localparam int CNT_W = $clog2(WORD_BITS);
  localparam int BC_W  = $clog2(WORD_BITS + 1);
  localparam int WIDE  = (WORD_BITS > TAIL_W) ? WORD_BITS : TAIL_W;
  localparam int RW    = ((VALUE_BITS > BC_W) ? VALUE_BITS : BC_W) + 1;

  logic                  busy_r;
  logic                  flush_r;
  logic [VALUE_BITS-1:0] ones_r;
  logic [TLEN_W-1:0]     tlen_r;
  logic [TAIL_W-1:0]     tbits_r;
  logic [WORD_BITS-1:0]  pend_r;
  logic [CNT_W-1:0]      cnt_r;

  logic                 step_en;
  logic                 take_ones;
  logic [RW-1:0]        space, avail, k;
  logic [RW-1:0]        ones_after, tlen_after, rem_after, fill;
  logic [WIDE-1:0]      kmask, ins, merged;
  logic [WORD_BITS-1:0] new_word;
  logic                 full_word;

  assign cmd_pop = !busy_r && !cmd_empty;
  assign step_en = busy_r && !out_full;

  always_comb begin
    space      = RW'(WORD_BITS) - RW'(cnt_r);
    take_ones  = (ones_r != '0);
    avail      = take_ones ? RW'(ones_r) : RW'(tlen_r);
    k          = (avail < space) ? avail : space;
    kmask      = ~({WIDE{1'b1}} << k);
    if (take_ones) begin
      ins = kmask;
    end else begin
      ins = (WIDE'(tbits_r) >> (RW'(tlen_r) - k)) & kmask;
    end
    merged     = (WIDE'(pend_r) << k) | ins;
    new_word   = merged[WORD_BITS-1:0];
    ones_after = take_ones ? (RW'(ones_r) - k) : RW'(ones_r);
    tlen_after = take_ones ? RW'(tlen_r) : (RW'(tlen_r) - k);
    rem_after  = ones_after + tlen_after;
    fill       = RW'(cnt_r) + k;
    full_word  = (fill == RW'(WORD_BITS));
  end

  // A word is the last of its request when what is left cannot fill another.
  always_comb begin
    if (flush_r) begin
      out_push      = step_en && (cnt_r != '0);
      out_word      = pend_r << (BC_W'(WORD_BITS) - BC_W'(cnt_r));
      out_bit_count = BC_W'(cnt_r);
      out_last      = 1'b1;
    end else begin
      out_push      = step_en && full_word;
      out_word      = new_word;
      out_bit_count = BC_W'(WORD_BITS);
      out_last      = (rem_after < RW'(WORD_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      flush_r <= 1'b0;
      ones_r  <= '0;
      tlen_r  <= '0;
      pend_r  <= '0;
      cnt_r   <= '0;
    end else if (cmd_pop) begin
      busy_r  <= 1'b1;
      flush_r <= cmd_tail.flush;
      ones_r  <= cmd_ones;
      tlen_r  <= cmd_tail.len;
    end else if (step_en) begin
      if (flush_r) begin
        pend_r <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b0;
      end else begin
        ones_r <= ones_after[VALUE_BITS-1:0];
        tlen_r <= tlen_after[TLEN_W-1:0];
        if (full_word) begin
          pend_r <= '0;
          cnt_r  <= '0;
        end else begin
          pend_r <= new_word;
          cnt_r  <= fill[CNT_W-1:0];
        end
        if (rem_after == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      tbits_r <= cmd_tail.bits;
    end
  end

endmodule

// ===== rtl/core/golomb_bitstream_encoder.sv =====
// Golomb bitstream encoder. An encode request passes the front end in steps
// (accept, one restoring-divider step per value bit, hand-off), the divider
// taking one bit a cycle. The back end packs up to one whole word a cycle
// while the result queue has room; its work on a long unary run overlaps
// the next division through a two-entry request queue. A flush request
// skips the division and goes from accept straight to hand-off. Results
// wait in a two-entry queue, so the output side may stall freely. The
// divisor is to be written only while idle.
// Depends on gbe_pkg, gbe_front, gbe_back and gbe_fifo.
module golomb_bitstream_encoder import gbe_pkg::*; #(
  parameter int VALUE_BITS = 10,
  parameter int WORD_BITS  = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_func,
  input  logic [VALUE_BITS-1:0]          in_value,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [WORD_BITS-1:0]           out_word,
  output logic [$clog2(WORD_BITS+1)-1:0] out_bit_count,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [DIV_W-1:0]               cfg_wdata
);

  localparam int BC_W  = $clog2(WORD_BITS + 1);
  localparam int CMD_W = VALUE_BITS + $bits(tail_t);
  localparam int RES_W = WORD_BITS + BC_W + 1;

  logic [DIV_W-1:0] divisor_r;

  logic                  cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [VALUE_BITS-1:0] f_ones, b_ones;
  tail_t                 f_tail, b_tail;

  logic                 res_push, res_full;
  logic [WORD_BITS-1:0] res_word;
  logic [BC_W-1:0]      res_bit_count;
  logic                 res_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r <= DIVISOR_RESET;
    end else if (cfg_we) begin
      divisor_r <= cfg_wdata;
    end
  end

  gbe_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_func  (in_func),
    .in_value (in_value),
    .in_full  (in_full),
    .divisor  (divisor_r),
    .cmd_push (cmd_push),
    .cmd_full (cmd_full),
    .cmd_ones (f_ones),
    .cmd_tail (f_tail)
  );

  gbe_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   ({f_ones, f_tail}),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  ({b_ones, b_tail}),
    .empty (cmd_empty)
  );

  gbe_back #(
    .VALUE_BITS (VALUE_BITS),
    .WORD_BITS  (WORD_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_empty     (cmd_empty),
    .cmd_pop       (cmd_pop),
    .cmd_ones      (b_ones),
    .cmd_tail      (b_tail),
    .out_full      (res_full),
    .out_push      (res_push),
    .out_word      (res_word),
    .out_bit_count (res_bit_count),
    .out_last      (res_last)
  );

  gbe_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   ({res_word, res_bit_count, res_last}),
    .full  (res_full),
    .pop   (out_pop),
    .dout  ({out_word, out_bit_count, out_last}),
    .empty (out_empty)
  );

  // A partial word only comes from a flush, which always closes its request.
  a_partial_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_bit_count != BC_W'(WORD_BITS))) |-> out_last)
    else $error("partial word without last");

  a_no_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_bit_count != '0))
    else $error("result word with no valid bits");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> in_full)
    else $error("front end free right after accepting a request");

  a_back_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("back end pushed into a full result queue");

endmodule
